FILE: hw/rtl/lsw_pkg.sv
// Shared types, constants and helpers for the link sequence and window timer block.
`default_nettype none

package lsw_pkg;

    // Sequence numbers wrap from SEQ_MAX back to zero
    localparam int SEQ_MAX    = 32767;
    localparam int SEQ_BITS   = 15;
    localparam int TIMER_BITS = 16;
    localparam int CFG_BITS   = 16;

    localparam logic [SEQ_BITS-1:0] CNT_MAX = {SEQ_BITS{1'b1}};
    localparam logic [SEQ_BITS-1:0] SEQ_TOP = SEQ_BITS'(SEQ_MAX);

    typedef logic [SEQ_BITS-1:0]   seq_t;
    typedef logic [TIMER_BITS-1:0] tmr_t;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_SENT      = 2'd1,
        MODE_RECEIVED  = 2'd2,
        MODE_LINK_DOWN = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_I = 2'd0,
        KIND_S = 2'd1,
        KIND_U = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ACK_TIMEOUT = 2'd0,
        CFG_SACK_DELAY  = 2'd1,
        CFG_IDLE_TEST   = 2'd2,
        CFG_RECV_WINDOW = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] ack_timeout_ticks;
        logic [15:0] sack_delay_ticks;
        logic [15:0] idle_test_ticks;
        seq_t        recv_window_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] frame_kind;
        logic       u_needs_confirm;
        seq_t       peer_send_seq;
        seq_t       peer_ack_seq;
    } item_t;

    typedef struct packed {
        logic send_s_request;
        logic send_test_request;
        logic link_failed;
        logic seq_error;
        seq_t close_ack_seq;
        seq_t send_seq;
        seq_t recv_seq;
        seq_t outstanding_k;
        seq_t unacked_w;
        logic ack_timer_active;
    } result_t;

    // Take a timer length in its low TIMER_BITS bits, zero-extending if wider
    function automatic tmr_t timer_len(input logic [15:0] v);
        logic [TIMER_BITS+15:0] ext;
        ext = {{TIMER_BITS{1'b0}}, v};
        return ext[TIMER_BITS-1:0];
    endfunction

    // Advance a sequence number with wrap at SEQ_MAX
    function automatic seq_t seq_next(input seq_t s);
        seq_t n;
        if (s >= SEQ_TOP) begin
            n = '0;
        end else begin
            n = s + seq_t'(1);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lsw_cfg_regs.sv
// Configuration register file: timer lengths and receive window limit.
`default_nettype none

module lsw_cfg_regs (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [lsw_pkg::CFG_BITS-1:0] cfg_data,
    output lsw_pkg::cfg_t                   cfg
);

    lsw_pkg::cfg_t cfg_reg;

    // Load reset defaults, then take writes by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_timeout_ticks <= 16'd15;
            cfg_reg.sack_delay_ticks  <= 16'd10;
            cfg_reg.idle_test_ticks   <= 16'd20;
            cfg_reg.recv_window_limit <= lsw_pkg::SEQ_BITS'(8);
        end else if (cfg_we) begin
            unique case (lsw_pkg::cfg_index_t'(cfg_index))
                lsw_pkg::CFG_ACK_TIMEOUT: cfg_reg.ack_timeout_ticks <= cfg_data;
                lsw_pkg::CFG_SACK_DELAY:  cfg_reg.sack_delay_ticks  <= cfg_data;
                lsw_pkg::CFG_IDLE_TEST:   cfg_reg.idle_test_ticks   <= cfg_data;
                lsw_pkg::CFG_RECV_WINDOW:
                    cfg_reg.recv_window_limit <= cfg_data[lsw_pkg::SEQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lsw_core.sv
// Link state registers and the single-pass event update logic.
`default_nettype none

module lsw_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step_en,
    input  wire lsw_pkg::item_t  item,
    input  wire lsw_pkg::cfg_t   cfg,
    output lsw_pkg::result_t     result
);

    lsw_pkg::seq_t send_seq_reg, send_seq_next;
    lsw_pkg::seq_t recv_seq_reg, recv_seq_next;
    lsw_pkg::seq_t k_reg, k_next;
    lsw_pkg::seq_t w_reg, w_next;
    lsw_pkg::tmr_t t1_reg, t1_next;
    lsw_pkg::tmr_t t2_reg, t2_next;
    lsw_pkg::tmr_t t3_reg, t3_next;
    logic [2:0]    run_reg, run_next;

    logic          s_req, t_req, failed, serr;
    lsw_pkg::seq_t close_ack;
    lsw_pkg::seq_t w_inc;
    lsw_pkg::seq_t k_ack;
    logic          t1_exp, t2_exp, t3_exp;

    // Window count after one more received I frame, saturating
    assign w_inc = (w_reg < lsw_pkg::CNT_MAX) ? w_reg + lsw_pkg::seq_t'(1) : w_reg;

    // Outstanding count after an acknowledge; beyond V(S) counts as one
    assign k_ack = (item.peer_ack_seq > send_seq_reg) ? lsw_pkg::seq_t'(1)
                                                      : send_seq_reg - item.peer_ack_seq;

    // Expiry of each running timer on a tick
    assign t1_exp = run_reg[0] && (t1_reg <= lsw_pkg::tmr_t'(1));
    assign t2_exp = run_reg[1] && (t2_reg <= lsw_pkg::tmr_t'(1));
    assign t3_exp = run_reg[2] && (t3_reg <= lsw_pkg::tmr_t'(1));

    // Work out next state and status for the current item
    always_comb begin
        send_seq_next = send_seq_reg;
        recv_seq_next = recv_seq_reg;
        k_next        = k_reg;
        w_next        = w_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        t3_next       = t3_reg;
        run_next      = run_reg;
        s_req         = 1'b0;
        t_req         = 1'b0;
        failed        = 1'b0;
        serr          = 1'b0;
        close_ack     = '0;

        unique case (lsw_pkg::mode_t'(item.mode))
            lsw_pkg::MODE_TICK: begin
                if (t1_exp) begin
                    failed        = 1'b1;
                    send_seq_next = '0;
                    recv_seq_next = '0;
                    k_next        = '0;
                    w_next        = '0;
                    t1_next       = '0;
                    t2_next       = '0;
                    t3_next       = '0;
                    run_next      = '0;
                end else begin
                    if (run_reg[0]) begin
                        t1_next = t1_reg - lsw_pkg::tmr_t'(1);
                    end
                    if (t2_exp) begin
                        s_req   = 1'b1;
                        t2_next = lsw_pkg::timer_len(cfg.sack_delay_ticks);
                    end else if (run_reg[1]) begin
                        t2_next = t2_reg - lsw_pkg::tmr_t'(1);
                    end
                    if (t3_exp) begin
                        t_req   = 1'b1;
                        t3_next = lsw_pkg::timer_len(cfg.idle_test_ticks);
                    end else if (run_reg[2]) begin
                        t3_next = t3_reg - lsw_pkg::tmr_t'(1);
                    end
                end
            end
            lsw_pkg::MODE_SENT: begin
                case (item.frame_kind)
                    lsw_pkg::KIND_I: begin
                        send_seq_next = lsw_pkg::seq_next(send_seq_reg);
                        k_next = (k_reg < lsw_pkg::CNT_MAX) ? k_reg + lsw_pkg::seq_t'(1)
                                                            : k_reg;
                        w_next = '0;
                        if (!run_reg[0]) begin
                            t1_next     = lsw_pkg::timer_len(cfg.ack_timeout_ticks);
                            run_next[0] = 1'b1;
                        end
                        t3_next     = lsw_pkg::timer_len(cfg.idle_test_ticks);
                        run_next[2] = 1'b1;
                    end
                    lsw_pkg::KIND_S: begin
                        w_next      = '0;
                        run_next[1] = 1'b0;
                        t2_next     = '0;
                        t3_next     = lsw_pkg::timer_len(cfg.idle_test_ticks);
                        run_next[2] = 1'b1;
                    end
                    lsw_pkg::KIND_U: begin
                        if (item.u_needs_confirm && !run_reg[0]) begin
                            t1_next     = lsw_pkg::timer_len(cfg.ack_timeout_ticks);
                            run_next[0] = 1'b1;
                        end
                        t3_next     = lsw_pkg::timer_len(cfg.idle_test_ticks);
                        run_next[2] = 1'b1;
                    end
                    default: ;
                endcase
            end
            lsw_pkg::MODE_RECEIVED: begin
                case (item.frame_kind)
                    lsw_pkg::KIND_I: begin
                        if (item.peer_send_seq != recv_seq_reg) begin
                            // Out of sequence: report V(R) for the closing S frame
                            serr          = 1'b1;
                            close_ack     = recv_seq_reg;
                            send_seq_next = '0;
                            recv_seq_next = '0;
                            k_next        = '0;
                            w_next        = '0;
                            t1_next       = '0;
                            t2_next       = '0;
                            t3_next       = '0;
                            run_next      = '0;
                        end else begin
                            recv_seq_next = lsw_pkg::seq_next(recv_seq_reg);
                            w_next        = w_inc;
                            k_next        = k_ack;
                            s_req         = (w_inc >= cfg.recv_window_limit);
                            run_next[0]   = 1'b0;
                            t1_next       = '0;
                            t2_next       = lsw_pkg::timer_len(cfg.sack_delay_ticks);
                            run_next[1]   = 1'b1;
                            t3_next       = lsw_pkg::timer_len(cfg.idle_test_ticks);
                            run_next[2]   = 1'b1;
                        end
                    end
                    lsw_pkg::KIND_S: begin
                        k_next      = k_ack;
                        t3_next     = lsw_pkg::timer_len(cfg.idle_test_ticks);
                        run_next[2] = 1'b1;
                    end
                    lsw_pkg::KIND_U: begin
                        run_next[0] = 1'b0;
                        t1_next     = '0;
                        t3_next     = lsw_pkg::timer_len(cfg.idle_test_ticks);
                        run_next[2] = 1'b1;
                    end
                    default: ;
                endcase
            end
            lsw_pkg::MODE_LINK_DOWN: begin
                send_seq_next = '0;
                recv_seq_next = '0;
                k_next        = '0;
                w_next        = '0;
                t1_next       = '0;
                t2_next       = '0;
                t3_next       = '0;
                run_next      = '0;
            end
            default: ;
        endcase
    end

    // Commit the state when an item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            send_seq_reg <= '0;
            recv_seq_reg <= '0;
            k_reg        <= '0;
            w_reg        <= '0;
            t1_reg       <= '0;
            t2_reg       <= '0;
            t3_reg       <= '0;
            run_reg      <= '0;
        end else if (step_en) begin
            send_seq_reg <= send_seq_next;
            recv_seq_reg <= recv_seq_next;
            k_reg        <= k_next;
            w_reg        <= w_next;
            t1_reg       <= t1_next;
            t2_reg       <= t2_next;
            t3_reg       <= t3_next;
            run_reg      <= run_next;
        end
    end

    // Status reflects the state after this item
    assign result.send_s_request    = s_req;
    assign result.send_test_request = t_req;
    assign result.link_failed       = failed;
    assign result.seq_error         = serr;
    assign result.close_ack_seq     = close_ack;
    assign result.send_seq          = send_seq_next;
    assign result.recv_seq          = recv_seq_next;
    assign result.outstanding_k     = k_next;
    assign result.unacked_w         = w_next;
    assign result.ack_timer_active  = run_next[0];

    // A stopped t1 or t2 always holds a zero count
    a_t1_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg[0] |-> (t1_reg == '0))
        else $error("t1 stopped with nonzero count");

    a_t2_stopped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !run_reg[1] |-> (t2_reg == '0))
        else $error("t2 stopped with nonzero count");

    // Link down clears the whole link state
    a_link_down_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.mode == lsw_pkg::MODE_LINK_DOWN) |=>
        (send_seq_reg == '0 && recv_seq_reg == '0 && k_reg == '0 && w_reg == '0 &&
         run_reg == '0))
        else $error("link down left state behind");

    // A tick never starts t1
    a_tick_no_t1_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.mode == lsw_pkg::MODE_TICK && !run_reg[0]) |=> !run_reg[0])
        else $error("t1 started on a tick");

    // A sequence error leaves V(R) cleared
    a_seq_error_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.seq_error) |=> (recv_seq_reg == '0 && run_reg == '0))
        else $error("sequence error did not reset the link");

endmodule

`default_nettype wire

FILE: hw/rtl/telecontrol_link_sequence_window_timers.sv
// Top level: input register, link control core, result register and config port.
//
//  channel  | direction | handshake        | payload
//  s_       | in        | s_valid/s_ready  | mode, frame_kind, u_needs_confirm, N(S), N(R)
//  m_       | out       | m_valid/m_ready  | requests, errors, V(S), V(R), k, w, t1 active
//  cfg_     | in        | cfg_we           | cfg_index, cfg_data (16 bits)
//
// One item per cycle sustained while m_ready is high; each item goes through the input
// register and then the result register between acceptance and its result.
// The link state updates in a single pass from the input register.
// aresetn (synchronous) clears the link state, timers and config to defaults.
// A stall on m_ready holds the result; the input register refills as soon as
// the result register frees up.
`default_nettype none

module telecontrol_link_sequence_window_timers (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // config
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [lsw_pkg::CFG_BITS-1:0] cfg_data,
    // event items
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic [1:0]                   s_mode,
    input  wire logic [1:0]                   s_frame_kind,
    input  wire logic                         s_u_needs_confirm,
    input  wire logic [lsw_pkg::SEQ_BITS-1:0] s_peer_send_seq,
    input  wire logic [lsw_pkg::SEQ_BITS-1:0] s_peer_ack_seq,
    // status items
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic                         m_send_s_request,
    output      logic                         m_send_test_request,
    output      logic                         m_link_failed,
    output      logic                         m_seq_error,
    output      logic [lsw_pkg::SEQ_BITS-1:0] m_close_ack_seq,
    output      logic [lsw_pkg::SEQ_BITS-1:0] m_send_seq,
    output      logic [lsw_pkg::SEQ_BITS-1:0] m_recv_seq,
    output      logic [lsw_pkg::SEQ_BITS-1:0] m_outstanding_k,
    output      logic [lsw_pkg::SEQ_BITS-1:0] m_unacked_w,
    output      logic                         m_ack_timer_active
);

    lsw_pkg::cfg_t    cfg;
    lsw_pkg::item_t   in_item_reg;
    logic             in_valid_reg;
    lsw_pkg::result_t core_result;
    lsw_pkg::result_t out_result_reg;
    logic             out_valid_reg;
    logic             advance;

    lsw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held item into the result register when it has room
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Hold the incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.mode            <= s_mode;
            in_item_reg.frame_kind      <= s_frame_kind;
            in_item_reg.u_needs_confirm <= s_u_needs_confirm;
            in_item_reg.peer_send_seq   <= s_peer_send_seq;
            in_item_reg.peer_ack_seq    <= s_peer_ack_seq;
        end
    end

    lsw_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_send_s_request    = out_result_reg.send_s_request;
    assign m_send_test_request = out_result_reg.send_test_request;
    assign m_link_failed       = out_result_reg.link_failed;
    assign m_seq_error         = out_result_reg.seq_error;
    assign m_close_ack_seq     = out_result_reg.close_ack_seq;
    assign m_send_seq          = out_result_reg.send_seq;
    assign m_recv_seq          = out_result_reg.recv_seq;
    assign m_outstanding_k     = out_result_reg.outstanding_k;
    assign m_unacked_w         = out_result_reg.unacked_w;
    assign m_ack_timer_active  = out_result_reg.ack_timer_active;

endmodule

`default_nettype wire

FILE: tb/telecontrol_link_sequence_window_timers_test.sv
// Self-checking testbench for the telecontrol link sequence, window and timer block.
`timescale 1ns / 100ps

module telecontrol_link_sequence_window_timers_test;

    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 200;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_we = 1'b0;
    logic [1:0]    cfg_index = lsw_pkg::CFG_ACK_TIMEOUT;
    logic [15:0]   cfg_data = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [1:0]    s_mode = lsw_pkg::MODE_TICK;
    logic [1:0]    s_frame_kind = lsw_pkg::KIND_I;
    logic          s_u_needs_confirm = 1'b0;
    lsw_pkg::seq_t s_peer_send_seq = '0;
    lsw_pkg::seq_t s_peer_ack_seq = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_send_s_request;
    logic          m_send_test_request;
    logic          m_link_failed;
    logic          m_seq_error;
    lsw_pkg::seq_t m_close_ack_seq;
    lsw_pkg::seq_t m_send_seq;
    lsw_pkg::seq_t m_recv_seq;
    lsw_pkg::seq_t m_outstanding_k;
    lsw_pkg::seq_t m_unacked_w;
    logic          m_ack_timer_active;

    telecontrol_link_sequence_window_timers u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_frame_kind        (s_frame_kind),
        .s_u_needs_confirm   (s_u_needs_confirm),
        .s_peer_send_seq     (s_peer_send_seq),
        .s_peer_ack_seq      (s_peer_ack_seq),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_send_s_request    (m_send_s_request),
        .m_send_test_request (m_send_test_request),
        .m_link_failed       (m_link_failed),
        .m_seq_error         (m_seq_error),
        .m_close_ack_seq     (m_close_ack_seq),
        .m_send_seq          (m_send_seq),
        .m_recv_seq          (m_recv_seq),
        .m_outstanding_k     (m_outstanding_k),
        .m_unacked_w         (m_unacked_w),
        .m_ack_timer_active  (m_ack_timer_active)
    );

    always #2 aclk = ~aclk;

    // Predicted link state and register copies
    lsw_pkg::seq_t lk_send_seq;
    lsw_pkg::seq_t lk_recv_seq;
    lsw_pkg::seq_t lk_k;
    lsw_pkg::seq_t lk_w;
    logic [15:0]   lk_t1;
    logic [15:0]   lk_t2;
    logic [15:0]   lk_t3;
    logic [2:0]    lk_running;
    logic [15:0]   reg_ack_timeout;
    logic [15:0]   reg_sack_delay;
    logic [15:0]   reg_idle_test;
    lsw_pkg::seq_t reg_recv_window;

    lsw_pkg::result_t status_due[$];
    int               mismatch_count = 0;
    int               quiet_cycles = 0;
    int               hold_left = 0;
    bit               idle_on = 1'b0;

    // Pause length: mostly none, some short, a few long
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic clear_link();
        lk_send_seq = '0;
        lk_recv_seq = '0;
        lk_k        = '0;
        lk_w        = '0;
        lk_t1       = '0;
        lk_t2       = '0;
        lk_t3       = '0;
        lk_running  = '0;
    endtask

    task automatic apply_ack(input lsw_pkg::seq_t nr);
        if (nr > lk_send_seq) lk_k = lsw_pkg::seq_t'(1);
        else lk_k = lk_send_seq - nr;
    endtask

    task automatic restart_idle_timer();
        lk_t3 = reg_idle_test;
        lk_running[2] = 1'b1;
    endtask

    task automatic start_ack_timer_if_idle();
        if (!lk_running[0]) begin
            lk_t1 = reg_ack_timeout;
            lk_running[0] = 1'b1;
        end
    endtask

    task automatic stop_ack_timer();
        lk_running[0] = 1'b0;
        lk_t1 = '0;
    endtask

    // Advance the predicted link state by one event and queue its status item
    task automatic step_link_state(input logic [1:0] md, input logic [1:0] kd,
                                   input logic cf, input lsw_pkg::seq_t ns,
                                   input lsw_pkg::seq_t nr);
        lsw_pkg::result_t r;
        r = '0;
        case (md)
            lsw_pkg::MODE_TICK: begin
                if (lk_running[0] && lk_t1 <= 16'd1) begin
                    r.link_failed = 1'b1;
                    clear_link();
                end else begin
                    if (lk_running[0]) lk_t1 = lk_t1 - 16'd1;
                    if (lk_running[1]) begin
                        if (lk_t2 <= 16'd1) begin
                            r.send_s_request = 1'b1;
                            lk_t2 = reg_sack_delay;
                        end else begin
                            lk_t2 = lk_t2 - 16'd1;
                        end
                    end
                    if (lk_running[2]) begin
                        if (lk_t3 <= 16'd1) begin
                            r.send_test_request = 1'b1;
                            lk_t3 = reg_idle_test;
                        end else begin
                            lk_t3 = lk_t3 - 16'd1;
                        end
                    end
                end
            end
            lsw_pkg::MODE_SENT: begin
                if (kd == lsw_pkg::KIND_I) begin
                    lk_send_seq = (lk_send_seq == lsw_pkg::seq_t'(lsw_pkg::SEQ_MAX)) ?
                                  '0 : lk_send_seq + 1'b1;
                    if (lk_k < lsw_pkg::CNT_MAX) lk_k = lk_k + 1'b1;
                    lk_w = '0;
                    start_ack_timer_if_idle();
                    restart_idle_timer();
                end else if (kd == lsw_pkg::KIND_S) begin
                    lk_w = '0;
                    lk_running[1] = 1'b0;
                    lk_t2 = '0;
                    restart_idle_timer();
                end else if (kd == lsw_pkg::KIND_U) begin
                    if (cf) start_ack_timer_if_idle();
                    restart_idle_timer();
                end
            end
            lsw_pkg::MODE_RECEIVED: begin
                if (kd == lsw_pkg::KIND_I) begin
                    if (ns != lk_recv_seq) begin
                        r.seq_error = 1'b1;
                        r.close_ack_seq = lk_recv_seq;
                        clear_link();
                    end else begin
                        lk_recv_seq = (lk_recv_seq == lsw_pkg::seq_t'(lsw_pkg::SEQ_MAX)) ?
                                      '0 : lk_recv_seq + 1'b1;
                        if (lk_w < lsw_pkg::CNT_MAX) lk_w = lk_w + 1'b1;
                        apply_ack(nr);
                        if (lk_w >= reg_recv_window) r.send_s_request = 1'b1;
                        stop_ack_timer();
                        lk_t2 = reg_sack_delay;
                        lk_running[1] = 1'b1;
                        restart_idle_timer();
                    end
                end else if (kd == lsw_pkg::KIND_S) begin
                    apply_ack(nr);
                    restart_idle_timer();
                end else if (kd == lsw_pkg::KIND_U) begin
                    stop_ack_timer();
                    restart_idle_timer();
                end
            end
            default: clear_link();
        endcase
        r.send_seq         = lk_send_seq;
        r.recv_seq         = lk_recv_seq;
        r.outstanding_k    = lk_k;
        r.unacked_w        = lk_w;
        r.ack_timer_active = lk_running[0];
        status_due.push_back(r);
    endtask

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Compare each status item with the oldest prediction
    always @(posedge aclk) begin
        lsw_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (status_due.size() == 0) begin
                report_mismatch("unexpected item", 1, 0);
            end else begin
                want = status_due.pop_front();
                if (m_send_s_request !== want.send_s_request)
                    report_mismatch("send_s_request", m_send_s_request, want.send_s_request);
                if (m_send_test_request !== want.send_test_request)
                    report_mismatch("send_test_request", m_send_test_request,
                                    want.send_test_request);
                if (m_link_failed !== want.link_failed)
                    report_mismatch("link_failed", m_link_failed, want.link_failed);
                if (m_seq_error !== want.seq_error)
                    report_mismatch("seq_error", m_seq_error, want.seq_error);
                if (m_close_ack_seq !== want.close_ack_seq)
                    report_mismatch("close_ack_seq", m_close_ack_seq, want.close_ack_seq);
                if (m_send_seq !== want.send_seq)
                    report_mismatch("send_seq", m_send_seq, want.send_seq);
                if (m_recv_seq !== want.recv_seq)
                    report_mismatch("recv_seq", m_recv_seq, want.recv_seq);
                if (m_outstanding_k !== want.outstanding_k)
                    report_mismatch("outstanding_k", m_outstanding_k, want.outstanding_k);
                if (m_unacked_w !== want.unacked_w)
                    report_mismatch("unacked_w", m_unacked_w, want.unacked_w);
                if (m_ack_timer_active !== want.ack_timer_active)
                    report_mismatch("ack_timer_active", m_ack_timer_active,
                                    want.ack_timer_active);
            end
        end
    end

    // Stall the status channel at random
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= 1'b1;
            hold_left <= pick_pause();
        end
    end

    // Abort when no item moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one event item, hold it until accepted, then predict its status
    task automatic send_event(input logic [1:0] md, input logic [1:0] kd,
                              input logic cf, input lsw_pkg::seq_t ns,
                              input lsw_pkg::seq_t nr);
        int gap;
        gap = idle_on ? pick_pause() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_mode            <= md;
        s_frame_kind      <= kd;
        s_u_needs_confirm <= cf;
        s_peer_send_seq   <= ns;
        s_peer_ack_seq    <= nr;
        do @(posedge aclk); while (!s_ready);
        step_link_state(md, kd, cf, ns, nr);
    endtask

    // Drop valid and wait for every predicted status item
    task automatic settle_link();
        s_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    // Write all four registers in turn, ack timeout first and receive window last
    task automatic load_config(input logic [15:0] ack, input logic [15:0] sack,
                               input logic [15:0] idle, input logic [15:0] window);
        cfg_we    <= 1'b1;
        cfg_index <= lsw_pkg::CFG_ACK_TIMEOUT;
        cfg_data  <= ack;
        @(posedge aclk);
        cfg_index <= lsw_pkg::CFG_SACK_DELAY;
        cfg_data  <= sack;
        @(posedge aclk);
        cfg_index <= lsw_pkg::CFG_IDLE_TEST;
        cfg_data  <= idle;
        @(posedge aclk);
        cfg_index <= lsw_pkg::CFG_RECV_WINDOW;
        cfg_data  <= window;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        reg_ack_timeout = ack;
        reg_sack_delay  = sack;
        reg_idle_test   = idle;
        reg_recv_window = window[14:0];
    endtask

    // N(R): mostly inside the outstanding window, sometimes beyond V(S)
    function automatic lsw_pkg::seq_t pick_ack();
        int r;
        int off;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            off = $urandom_range(0, lk_k);
            return (off > lk_send_seq) ? lsw_pkg::seq_t'(0)
                                       : lk_send_seq - lsw_pkg::seq_t'(off);
        end
        if (r < 9) return lk_send_seq + lsw_pkg::seq_t'($urandom_range(1, 3));
        return lsw_pkg::seq_t'($urandom);
    endfunction

    task automatic send_random_event();
        int            pick;
        logic [1:0]    md;
        logic [1:0]    kd;
        logic          cf;
        lsw_pkg::seq_t ns;
        lsw_pkg::seq_t nr;
        pick = $urandom_range(0, 99);
        md = lsw_pkg::MODE_TICK;
        kd = lsw_pkg::KIND_I;
        cf = 1'($urandom_range(0, 1));
        ns = lsw_pkg::seq_t'($urandom);
        nr = lsw_pkg::seq_t'($urandom);
        if (pick < 35) begin
            md = lsw_pkg::MODE_TICK;
        end else if (pick < 50) begin
            md = lsw_pkg::MODE_SENT;
            kd = lsw_pkg::KIND_I;
        end else if (pick < 55) begin
            md = lsw_pkg::MODE_SENT;
            kd = lsw_pkg::KIND_S;
        end else if (pick < 60) begin
            md = lsw_pkg::MODE_SENT;
            kd = lsw_pkg::KIND_U;
        end else if (pick < 80) begin
            md = lsw_pkg::MODE_RECEIVED;
            kd = lsw_pkg::KIND_I;
            ns = lk_recv_seq;
            nr = pick_ack();
        end else if (pick < 86) begin
            md = lsw_pkg::MODE_RECEIVED;
            kd = lsw_pkg::KIND_S;
            nr = pick_ack();
        end else if (pick < 90) begin
            md = lsw_pkg::MODE_RECEIVED;
            kd = lsw_pkg::KIND_U;
        end else if (pick < 93) begin
            md = lsw_pkg::MODE_RECEIVED;
            kd = lsw_pkg::KIND_I;
            ns = lk_recv_seq ^ lsw_pkg::seq_t'($urandom_range(1, lsw_pkg::SEQ_MAX));
        end else if (pick < 95) begin
            md = lsw_pkg::MODE_LINK_DOWN;
        end else begin
            md = 2'($urandom_range(0, 3));
            kd = 2'($urandom_range(0, 3));
        end
        send_event(md, kd, cf, ns, nr);
    endtask

    // Every event kind under the reset register values
    task automatic test_event_kinds();
        idle_on = 1'b1;
        send_event(lsw_pkg::MODE_TICK, lsw_pkg::KIND_I, 1'b0, '0, '0);
        send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_I, 1'b0, '0, '0);
        send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_U, 1'b1, '0, '0);
        send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_S, 1'b0, '0, '0);
        send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_S, 1'b0, '0, lsw_pkg::CNT_MAX);
        send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_I, 1'b1, '0, lsw_pkg::seq_t'(1));
        send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_S, 1'b0, lsw_pkg::CNT_MAX,
                   lsw_pkg::CNT_MAX);
        send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_U, 1'b1, '0, '0);
        send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_U, 1'b0, '0, '0);
        send_event(lsw_pkg::MODE_SENT, 2'd3, 1'b1, lsw_pkg::CNT_MAX, lsw_pkg::CNT_MAX);
        send_event(lsw_pkg::MODE_RECEIVED, 2'd3, 1'b1, lsw_pkg::CNT_MAX, lsw_pkg::CNT_MAX);
        send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_I, 1'b0, lsw_pkg::CNT_MAX, '0);
        send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_I, 1'b0, '0, '0);
        send_event(lsw_pkg::MODE_LINK_DOWN, lsw_pkg::KIND_U, 1'b1, lsw_pkg::CNT_MAX,
                   lsw_pkg::CNT_MAX);
        settle_link();
    endtask

    // Expire t2, t3 and then t1, with a window limit of zero
    task automatic test_timer_expiry();
        load_config(16'd4, 16'd2, 16'd3, 16'd0);
        send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_I, 1'b0, lk_recv_seq, '0);
        repeat (4) send_event(lsw_pkg::MODE_TICK, lsw_pkg::KIND_I, 1'b0, '0, '0);
        send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_U, 1'b1, '0, '0);
        repeat (5) send_event(lsw_pkg::MODE_TICK, lsw_pkg::KIND_I, 1'b0, '0, '0);
        settle_link();
    endtask

    // Run k, w and both sequence counters up from a cleared link, back to back
    task automatic test_counter_climb();
        idle_on = 1'b0;
        load_config(16'd15, 16'd10, 16'd20, 16'd8);
        send_event(lsw_pkg::MODE_LINK_DOWN, lsw_pkg::KIND_I, 1'b0, '0, '0);
        repeat (60) send_event(lsw_pkg::MODE_SENT, lsw_pkg::KIND_I, 1'b0, '0, '0);
        repeat (60)
            send_event(lsw_pkg::MODE_RECEIVED, lsw_pkg::KIND_I, 1'b0, lk_recv_seq,
                       lk_send_seq);
        settle_link();
    endtask

    // Random traffic under one register setting
    task automatic test_random_traffic(input logic [15:0] ack, input logic [15:0] sack,
                                       input logic [15:0] idle, input logic [15:0] window,
                                       input bit with_idling, input int count);
        load_config(ack, sack, idle, window);
        idle_on = with_idling;
        repeat (count) send_random_event();
        settle_link();
    endtask

    initial begin
        reg_ack_timeout = 16'd15;
        reg_sack_delay  = 16'd10;
        reg_idle_test   = 16'd20;
        reg_recv_window = lsw_pkg::seq_t'(8);
        clear_link();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_event_kinds();
        test_timer_expiry();
        test_counter_climb();
        test_random_traffic(16'd15, 16'd10, 16'd20, 16'd8, 1'b1, 250);
        test_random_traffic(16'd1, 16'd1, 16'd1, 16'd1, 1'b1, 250);
        test_random_traffic(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b0, 250);
        test_random_traffic(16'($urandom_range(3, 40)), 16'($urandom_range(1, 20)),
                            16'($urandom_range(1, 30)), 16'($urandom_range(1, 12)),
                            1'b1, 250);
        test_random_traffic(16'd6, 16'd3, 16'd5, 16'd0, 1'b1, 250);

        settle_link();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
